// ===== rtl/gipt_pkg.sv =====
// Shared types, constants and helpers for the greedy intensity path tracer.
// No dependencies; every other file imports this package.
package gipt_pkg;

  localparam int COORD_W         = 5;
  localparam int LEVEL_W         = 8;
  localparam int SUM_W           = 10;
  localparam int PROD_W          = 2 * SUM_W;
  localparam int VALUE_W         = 16;
  localparam int CFG_W           = 6;
  localparam int PAIR_W          = 5;
  localparam int MAX_PAIRS       = 31;
  localparam int POINT_W         = 2 * COORD_W;
  localparam int IMAGE_SIDE_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int DIV3_SHIFT      = 11;

  localparam logic [SUM_W-1:0]   DIV3_MUL     = 10'd683;
  localparam logic [VALUE_W-1:0] OUT_OF_RANGE = 16'hFF00;
  localparam logic [CFG_W-1:0]   DIM_RESET    = 6'd32;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_TRACE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    SLOT_CENTER = 2'd0,
    SLOT_HORIZ  = 2'd1,
    SLOT_DIAG   = 2'd2,
    SLOT_VERT   = 2'd3
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_WAIT,
    ST_MOVE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [LEVEL_W-1:0] blue;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] red;
    logic [COORD_W-1:0] begin_x;
    logic [COORD_W-1:0] begin_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } request_t;

  typedef struct packed {
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic               last_point;
  } result_t;

  typedef struct packed {
    kind_t              kind;
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
    logic [LEVEL_W-1:0] level;
  } cmd_t;

  function automatic logic [COORD_W-1:0] coord_step(input logic [COORD_W-1:0] c,
                                                    input logic neg);
    return neg ? c - COORD_W'(1) : c + COORD_W'(1);
  endfunction

endpackage

// ===== rtl/greedy_intensity_path_tracer_core.sv =====
// Top level of the greedy intensity path tracer: configuration registers,
// front end, command queue and walk engine. Depends on gipt_pkg.
//
//   channel   ports                            handshake
//   request   start, busy, req                 taken when start && !busy
//   result    result_strobe, result            one strobe per point, no stall
//   config    cfg_we, cfg_addr, cfg_wdata      written when cfg_we
//
// A trace walks D diagonal steps (eight serial reads of the single memory
// read port plus one wait and one move per side), then S straight steps,
// and drains P end-side points from the stack.
// Reset clears control state; image memory contents are undefined until
// loaded. busy rises only while the command queue is full.
module greedy_intensity_path_tracer_core #(
  parameter int IMAGE_SIDE  = gipt_pkg::IMAGE_SIDE_DEF,
  parameter int QUEUE_DEPTH = gipt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  gipt_pkg::request_t          req,
  output logic                        result_strobe,
  output gipt_pkg::result_t           result,
  input  logic                        cfg_we,
  input  logic                        cfg_addr,
  input  logic [gipt_pkg::CFG_W-1:0]  cfg_wdata
);
  import gipt_pkg::*;

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic             push;
  cmd_t             push_cmd;
  cmd_t             head;
  logic             pop;
  logic             empty;
  logic             full;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_RESET;
      image_height <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_IMAGE_WIDTH:  image_width  <= cfg_wdata;
        REG_IMAGE_HEIGHT: image_height <= cfg_wdata;
        default:          image_width  <= image_width;
      endcase
    end
  end

  gipt_front #(
    .IMAGE_SIDE (IMAGE_SIDE)
  ) u_front (
    .start (start),
    .req   (req),
    .full  (full),
    .busy  (busy),
    .push  (push),
    .cmd   (push_cmd)
  );

  gipt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  gipt_back #(
    .IMAGE_SIDE (IMAGE_SIDE)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .image_width   (image_width),
    .image_height  (image_height),
    .result_strobe (result_strobe),
    .result        (result)
  );

endmodule

// ===== rtl/gipt_front.sv =====
// Front end: accepts requests, drops loads outside the image memory, computes
// the load intensity. Depends on gipt_pkg.
module gipt_front #(
  parameter int IMAGE_SIDE = gipt_pkg::IMAGE_SIDE_DEF
) (
  input  logic              start,
  input  gipt_pkg::request_t req,
  input  logic              full,
  output logic              busy,
  output logic              push,
  output gipt_pkg::cmd_t    cmd
);
  import gipt_pkg::*;

  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;
  logic              in_mem;
  logic              keep;

  assign sum    = SUM_W'(req.blue) + SUM_W'(req.green) + SUM_W'(req.red);
  assign prod   = PROD_W'(sum) * PROD_W'(DIV3_MUL);
  assign in_mem = ({1'b0, req.pixel_x} < CFG_W'(IMAGE_SIDE)) &&
                  ({1'b0, req.pixel_y} < CFG_W'(IMAGE_SIDE));
  assign keep   = (req.kind == KIND_TRACE) || in_mem;

  assign busy = full;
  assign push = start && !full && keep;

  always_comb begin
    cmd.kind  = req.kind;
    cmd.ax    = (req.kind == KIND_LOAD) ? req.pixel_x : req.begin_x;
    cmd.ay    = (req.kind == KIND_LOAD) ? req.pixel_y : req.begin_y;
    cmd.bx    = req.end_x;
    cmd.by    = req.end_y;
    cmd.level = prod[DIV3_SHIFT +: LEVEL_W];
  end

endmodule

// ===== rtl/gipt_queue.sv =====
// Short command queue between the front end and the walk engine.
// Depends on gipt_pkg for the command type.
module gipt_queue #(
  parameter int DEPTH = gipt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gipt_pkg::cmd_t push_cmd,
  input  logic           pop,
  output gipt_pkg::cmd_t head,
  output logic           empty,
  output logic           full
);
  import gipt_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/gipt_back.sv =====
// Walk engine: image memory, neighbour search sequencer, end-side stack and
// result register. Depends on gipt_pkg.
module gipt_back #(
  parameter int IMAGE_SIDE = gipt_pkg::IMAGE_SIDE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  gipt_pkg::cmd_t               head,
  input  logic                         empty,
  output logic                         pop,
  input  logic [gipt_pkg::CFG_W-1:0]   image_width,
  input  logic [gipt_pkg::CFG_W-1:0]   image_height,
  output logic                         result_strobe,
  output gipt_pkg::result_t            result
);
  import gipt_pkg::*;

  localparam int DEPTH = IMAGE_SIDE * IMAGE_SIDE;
  localparam int AW    = $clog2(DEPTH);

  logic [LEVEL_W-1:0] mem [DEPTH];
  logic [POINT_W-1:0] stack [MAX_PAIRS];

  state_t state;
  state_t state_next;

  logic [COORD_W-1:0] bx, by, ex, ey;
  logic               negx, negy;
  logic [PAIR_W-1:0]  pairs;
  logic               side;
  slot_t              slot;
  slot_t              pick;
  logic [VALUE_W-1:0] centre;
  logic [VALUE_W-1:0] best;
  logic               rvalid;
  slot_t              rslot;
  logic               roor;
  logic [LEVEL_W-1:0] rdata;

  logic               gap_x, gap_y, at_limit;
  logic               load_trace, mem_we;
  logic               enter_read, rd_issue, mv, step_v, step_h, drain_emit;
  logic               mvx, mvy, emit_begin, stack_we;
  logic [COORD_W-1:0] nbx, nby, nex, ney;
  logic [COORD_W-1:0] cx, cy, nx, ny;
  logic [CFG_W-1:0]   lim_w, lim_h;
  logic               oor;
  logic [AW-1:0]      raddr, waddr;
  logic [VALUE_W-1:0] rvalue, diff;
  logic [POINT_W-1:0] top_point;

  assign gap_x    = negx ? (bx > ex) : (ex > bx);
  assign gap_y    = negy ? (by > ey) : (ey > by);
  assign at_limit = (pairs == PAIR_W'(MAX_PAIRS));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!empty && head.kind == KIND_TRACE) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (at_limit) begin
          state_next = ST_DRAIN;
        end else if (gap_x && gap_y) begin
          state_next = ST_READ;
        end else if (!gap_x && !gap_y) begin
          state_next = ST_DRAIN;
        end
      end
      ST_READ: begin
        if (slot == SLOT_VERT) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT:  state_next = ST_MOVE;
      ST_MOVE:  state_next = side ? ST_CHECK : ST_READ;
      ST_DRAIN: begin
        if (pairs <= PAIR_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    enter_read = 1'b0;
    rd_issue   = 1'b0;
    mv         = 1'b0;
    step_v     = 1'b0;
    step_h     = 1'b0;
    drain_emit = 1'b0;
    case (state)
      ST_IDLE:  pop = !empty;
      ST_CHECK: begin
        if (!at_limit) begin
          if (gap_x && gap_y) begin
            enter_read = 1'b1;
          end else if (gap_y) begin
            step_v = 1'b1;
          end else if (gap_x) begin
            step_h = 1'b1;
          end
        end
      end
      ST_READ:  rd_issue   = 1'b1;
      ST_MOVE:  mv         = 1'b1;
      ST_DRAIN: drain_emit = (pairs != '0);
      default:  pop        = 1'b0;
    endcase
  end

  assign load_trace = pop && (head.kind == KIND_TRACE);
  assign mem_we     = pop && (head.kind == KIND_LOAD);

  assign mvx = mv && (pick == SLOT_HORIZ || pick == SLOT_DIAG);
  assign mvy = mv && (pick == SLOT_DIAG || pick == SLOT_VERT);
  assign nbx = ((mvx && !side) || step_h) ? coord_step(bx, negx)  : bx;
  assign nby = ((mvy && !side) || step_v) ? coord_step(by, negy)  : by;
  assign nex = ((mvx && side)  || step_h) ? coord_step(ex, !negx) : ex;
  assign ney = ((mvy && side)  || step_v) ? coord_step(ey, !negy) : ey;

  assign emit_begin = (mv && !side) || step_v || step_h;
  assign stack_we   = (mv && side) || step_v || step_h;
  assign top_point  = stack[PAIR_W'(pairs - PAIR_W'(1))];

  assign cx    = side ? ex : bx;
  assign cy    = side ? ey : by;
  assign nx    = (slot == SLOT_HORIZ || slot == SLOT_DIAG) ? coord_step(cx, negx ^ side) : cx;
  assign ny    = (slot == SLOT_DIAG || slot == SLOT_VERT)  ? coord_step(cy, negy ^ side) : cy;
  assign lim_w = (image_width  < CFG_W'(IMAGE_SIDE)) ? image_width  : CFG_W'(IMAGE_SIDE);
  assign lim_h = (image_height < CFG_W'(IMAGE_SIDE)) ? image_height : CFG_W'(IMAGE_SIDE);
  assign oor   = ({1'b0, nx} >= lim_w) || ({1'b0, ny} >= lim_h);
  assign raddr = AW'(int'(ny) * IMAGE_SIDE + int'(nx));
  assign waddr = AW'(int'(head.ay) * IMAGE_SIDE + int'(head.ax));

  assign rvalue = roor ? OUT_OF_RANGE : {{(VALUE_W - LEVEL_W){1'b0}}, rdata};
  assign diff   = (centre >= rvalue) ? centre - rvalue : rvalue - centre;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= head.level;
    end
    rdata <= mem[raddr];
    roor  <= oor;
    rslot <= slot;
  end

  always_ff @(posedge clk) begin
    if (rvalid) begin
      if (rslot == SLOT_CENTER) begin
        centre <= rvalue;
      end else if (rslot == SLOT_HORIZ || diff < best) begin
        best <= diff;
        pick <= rslot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack[pairs] <= {ney, nex};
    end
  end

  always_ff @(posedge clk) begin
    if (load_trace) begin
      bx   <= head.ax;
      by   <= head.ay;
      ex   <= head.bx;
      ey   <= head.by;
      negx <= !(head.bx > head.ax);
      negy <= !(head.by > head.ay);
    end else begin
      bx <= nbx;
      by <= nby;
      ex <= nex;
      ey <= ney;
    end
    if (drain_emit) begin
      result.point_x    <= top_point[COORD_W-1:0];
      result.point_y    <= top_point[POINT_W-1:COORD_W];
      result.last_point <= (pairs == PAIR_W'(1));
    end else begin
      result.point_x    <= nbx;
      result.point_y    <= nby;
      result.last_point <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pairs         <= '0;
      side          <= 1'b0;
      slot          <= SLOT_CENTER;
      rvalid        <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      rvalid        <= rd_issue;
      result_strobe <= emit_begin || drain_emit;
      if (load_trace) begin
        pairs <= '0;
      end else if (stack_we) begin
        pairs <= pairs + PAIR_W'(1);
      end else if (drain_emit) begin
        pairs <= pairs - PAIR_W'(1);
      end
      if (enter_read) begin
        side <= 1'b0;
        slot <= SLOT_CENTER;
      end else if (rd_issue) begin
        slot <= slot_t'(slot + 2'd1);
      end else if (mv) begin
        side <= !side;
        slot <= SLOT_CENTER;
      end
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for greedy_intensity_path_tracer_core: pixel loads and path traces
// checked point by point against a scoreboard with its own intensity image.
// Depends on gipt_pkg and the core RTL.
import gipt_pkg::*;

localparam int SIDE = IMAGE_SIDE_DEF;

typedef enum int {
  STEP_HORIZ,
  STEP_DIAG,
  STEP_VERT
} step_t;

class path_checker;
  bit [LEVEL_W-1:0] level [SIDE][SIDE];
  int               width_reg;
  int               height_reg;
  result_t          expected_points[$];
  int               errors;

  function new();
    width_reg  = SIDE;
    height_reg = SIDE;
    errors     = 0;
  endfunction

  function void set_register(logic idx, int value);
    if (idx == REG_IMAGE_WIDTH) begin
      width_reg = value;
    end else begin
      height_reg = value;
    end
  endfunction

  function int read_level(int x, int y);
    int wl, hl;
    wl = (width_reg < SIDE) ? width_reg : SIDE;
    hl = (height_reg < SIDE) ? height_reg : SIDE;
    if (x < 0 || y < 0 || x >= wl || y >= hl) return int'(OUT_OF_RANGE);
    return int'(level[y][x]);
  endfunction

  function int step_x(int i, int dx);
    return (i == STEP_VERT) ? 0 : dx;
  endfunction

  function int step_y(int i, int dy);
    return (i == STEP_HORIZ) ? 0 : dy;
  endfunction

  function int pick_dir(int x, int y, int sgn, int dx, int dy);
    int centre, best, pick, d;
    centre = read_level(x, y);
    best   = -1;
    pick   = STEP_HORIZ;
    for (int i = STEP_HORIZ; i <= STEP_VERT; i++) begin
      d = centre - read_level(x + sgn * step_x(i, dx), y + sgn * step_y(i, dy));
      if (d < 0) d = -d;
      if (best < 0 || d < best) begin
        best = d;
        pick = i;
      end
    end
    return pick;
  endfunction

  function result_t make_point(int x, int y);
    result_t p;
    p.point_x    = x[COORD_W-1:0];
    p.point_y    = y[COORD_W-1:0];
    p.last_point = 1'b0;
    return p;
  endfunction

  function void note_request(request_t r);
    int      bx, by, ex, ey, dirx, diry, pairs, h;
    result_t far_side[$];
    if (r.kind == KIND_LOAD) begin
      level[r.pixel_y][r.pixel_x] =
        LEVEL_W'((int'(r.blue) + int'(r.green) + int'(r.red)) / 3);
      return;
    end
    bx    = r.begin_x;
    by    = r.begin_y;
    ex    = r.end_x;
    ey    = r.end_y;
    dirx  = (ex - bx > 0) ? 1 : -1;
    diry  = (ey - by > 0) ? 1 : -1;
    pairs = 0;
    while (pairs < MAX_PAIRS && (ex - bx) * dirx > 0 && (ey - by) * diry > 0) begin
      h  = pick_dir(bx, by, 1, dirx, diry);
      bx += step_x(h, dirx);
      by += step_y(h, diry);
      expected_points = {expected_points, make_point(bx, by)};
      h  = pick_dir(ex, ey, -1, dirx, diry);
      ex -= step_x(h, dirx);
      ey -= step_y(h, diry);
      far_side = {far_side, make_point(ex, ey)};
      pairs++;
    end
    while (pairs < MAX_PAIRS && (ey - by) * diry > 0) begin
      by += diry;
      expected_points = {expected_points, make_point(bx, by)};
      ey -= diry;
      far_side = {far_side, make_point(ex, ey)};
      pairs++;
    end
    while (pairs < MAX_PAIRS && (ex - bx) * dirx > 0) begin
      bx += dirx;
      expected_points = {expected_points, make_point(bx, by)};
      ex -= dirx;
      far_side = {far_side, make_point(ex, ey)};
      pairs++;
    end
    while (far_side.size() > 0) expected_points = {expected_points, far_side.pop_back()};
    if (pairs > 0) expected_points[expected_points.size()-1].last_point = 1'b1;
  endfunction

  function void check_point(result_t got);
    result_t want;
    if (expected_points.size() == 0) begin
      $error("unexpected point: x %0d y %0d last %0d",
             got.point_x, got.point_y, got.last_point);
      errors++;
      return;
    end
    want = expected_points.pop_front();
    if (got.point_x !== want.point_x) begin
      $error("point_x: expected %0d, got %0d", want.point_x, got.point_x);
      errors++;
    end
    if (got.point_y !== want.point_y) begin
      $error("point_y: expected %0d, got %0d", want.point_y, got.point_y);
      errors++;
    end
    if (got.last_point !== want.last_point) begin
      $error("last_point: expected %0d, got %0d", want.last_point, got.last_point);
      errors++;
    end
  endfunction

  function int pending();
    return expected_points.size();
  endfunction
endclass

module tb;
  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             start     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic             cfg_addr  = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  request_t         req       = '0;
  logic             busy;
  logic             result_strobe;
  result_t          result;

  path_checker sb = new();
  bit          loaded [SIDE][SIDE];
  int          idle_pct = 35;
  int          dim_w    = SIDE;
  int          dim_h    = SIDE;
  int          item_count = 0;
  int          phase_w[7] = '{32, 1, 32, 1, 7, 20, 32};
  int          phase_h[7] = '{32, 1, 1, 32, 12, 9, 17};

  greedy_intensity_path_tracer_core dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req           (req),
    .result_strobe (result_strobe),
    .result        (result),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && result_strobe) sb.check_point(result);
  end

  function request_t random_request();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return request_t'(raw[$bits(request_t)-1:0]);
  endfunction

  function int clamp_coord(int v);
    return (v < 0) ? 0 : (v > SIDE - 1) ? SIDE - 1 : v;
  endfunction

  // hold start high until the request is taken; caller keeps or drops start in the same step
  task automatic send_request(request_t r);
    idle_pct = (item_count < 133) ? 35 : (item_count < 266) ? 88 : 0;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    sb.note_request(r);
    item_count++;
  endtask

  task automatic load_pixel(int x, int y);
    request_t r;
    int       shade;
    r         = random_request();
    r.kind    = KIND_LOAD;
    r.pixel_x = x[COORD_W-1:0];
    r.pixel_y = y[COORD_W-1:0];
    if ($urandom_range(1)) begin
      case ($urandom_range(5))
        0: shade = 0;
        1: shade = 1;
        2: shade = 2;
        3: shade = 128;
        4: shade = 254;
        default: shade = 255;
      endcase
      r.blue  = shade[LEVEL_W-1:0];
      r.green = shade[LEVEL_W-1:0];
      r.red   = shade[LEVEL_W-1:0];
    end
    loaded[y][x] = 1'b1;
    send_request(r);
  endtask

  // load every unwritten in-range pixel of the box first, then request the trace
  task automatic trace_path(int bx, int by, int ex, int ey);
    request_t r;
    int       x0, x1, y0, y1;
    x0 = (bx < ex) ? bx : ex;
    y0 = (by < ey) ? by : ey;
    x1 = (bx > ex) ? bx : ex;
    y1 = (by > ey) ? by : ey;
    if (x1 > dim_w - 1) x1 = dim_w - 1;
    if (y1 > dim_h - 1) y1 = dim_h - 1;
    for (int y = y0; y <= y1; y++) begin
      for (int x = x0; x <= x1; x++) begin
        if (!loaded[y][x]) load_pixel(x, y);
      end
    end
    r         = random_request();
    r.kind    = KIND_TRACE;
    r.begin_x = bx[COORD_W-1:0];
    r.begin_y = by[COORD_W-1:0];
    r.end_x   = ex[COORD_W-1:0];
    r.end_y   = ey[COORD_W-1:0];
    send_request(r);
  endtask

  task automatic write_dims(int w, int h);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_IMAGE_WIDTH;
    cfg_wdata <= w[CFG_W-1:0];
    @(posedge clk);
    sb.set_register(REG_IMAGE_WIDTH, w);
    cfg_addr  <= REG_IMAGE_HEIGHT;
    cfg_wdata <= h[CFG_W-1:0];
    @(posedge clk);
    sb.set_register(REG_IMAGE_HEIGHT, h);
    cfg_we    <= 1'b0;
    dim_w = w;
    dim_h = h;
  endtask

  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_item();
    int roll, bx, by;
    roll = $urandom_range(99);
    bx   = $urandom_range(SIDE - 1);
    by   = $urandom_range(SIDE - 1);
    if (roll < 35) begin
      load_pixel(bx, by);
    end else if (roll < 40) begin
      trace_path(bx, by, bx, by);
    end else if (roll < 50) begin
      trace_path(bx, by, $urandom_range(SIDE - 1), $urandom_range(SIDE - 1));
    end else begin
      trace_path(bx, by, clamp_coord(bx + $urandom_range(12) - 6),
                 clamp_coord(by + $urandom_range(12) - 6));
    end
  endtask

  initial begin
    int phase_end;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_dims(4, 4);

    load_pixel(0, 0);
    load_pixel(31, 31);
    trace_path(0, 0, 0, 0);
    trace_path(0, 0, 31, 31);
    trace_path(31, 31, 0, 0);
    trace_path(31, 0, 0, 31);
    trace_path(0, 31, 31, 0);
    trace_path(0, 5, 0, 20);
    trace_path(20, 2, 2, 2);
    trace_path(2, 2, 3, 3);
    trace_path(3, 0, 0, 3);
    trace_path(1, 1, 31, 2);
    start <= 1'b0;
    settle();

    for (int p = 0; p < 7; p++) begin
      write_dims(phase_w[p], phase_h[p]);
      phase_end = item_count + 53;
      while (item_count < phase_end) random_item();
      start <= 1'b0;
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

// ===== greedy_intensity_path_tracer_core.f =====
rtl/gipt_pkg.sv
rtl/gipt_front.sv
rtl/gipt_queue.sv
rtl/gipt_back.sv
rtl/greedy_intensity_path_tracer_core.sv
verif/tb.sv
